>>> rtl/kpdc_pkg.sv
`default_nettype none
package kpdc_pkg;

  localparam int COUNT_BITS_DEF = 21;
  localparam int TICK_BITS      = 20;
  localparam int KEY_LANES      = 9;
  localparam int KNOB_LANES     = 6;
  localparam int LANES          = KEY_LANES + KNOB_LANES;

  localparam logic [TICK_BITS-1:0] SHORT_TICKS_RST = 20'd1000;
  localparam logic [TICK_BITS-1:0] LONG_TICKS_RST  = 20'd96000;
  localparam logic                 SIX_KEY_RST     = 1'b1;

  localparam logic [17:0] FOOT_GROUP_MASK  = 18'h3F000;
  localparam logic [17:0] FRONT_GROUP_MASK = 18'h00FFF;

  typedef enum logic [1:0] {
    EVT_NONE  = 2'd0,
    EVT_SHORT = 2'd1,
    EVT_LONG  = 2'd2
  } evt_t;

  typedef enum logic [1:0] {
    REG_SHORT_TICKS = 2'd0,
    REG_LONG_TICKS  = 2'd1,
    REG_SIX_KEY     = 2'd2
  } reg_idx_t;

  // Press thresholds shared by every lane
  typedef struct packed {
    logic [TICK_BITS-1:0] short_ticks;
    logic [TICK_BITS-1:0] long_ticks;
  } thresh_t;

endpackage
`default_nettype wire

>>> rtl/key_press_duration_classifier_top.sv
`default_nettype none
// Key press duration classifier.
// Input stream (in_*): one item per sample tick carrying the raw active-low
// levels of six front keys, two foot switches and six knob push keys.
// Output stream (out_*): one item per input item with a 2-bit event code per
// channel (0 none, 1 short press, 2 long press) for that tick only.
// Fifteen counter lanes run side by side, one per channel; the foot lines are
// decoded into three exclusive channels (one only, two only, both). A merge
// stage packs the lane codes and, with six-key mode off, applies the four-key remap.
// Each result is registered in the output register as its item is accepted.
// Throughput: one item per cycle; the lane counters plus the output register
// set that figure, and a new item is accepted whenever the output register
// is empty or being drained in the same cycle.
// Receiver stall: the pending result holds in the output register and
// in_tready drops until it is taken; counters advance only on accepted items.
// Reset (synchronous, rst_n low): all hold counts clear, the output register
// empties, thresholds return to 1000 / 96000 ticks and six-key mode is set.
// Configuration: APB registers at 0x0 short_ticks, 0x4 long_ticks,
// 0x8 six_key_mode; write them only while the block is idle.
module key_press_duration_classifier_top #(
  parameter int COUNT_BITS = kpdc_pkg::COUNT_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // key_levels[5:0], foot_levels[7:6], knob_key_levels[13:8]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // key_events[17:0], knob_key_events[29:18]
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [3:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);
  import kpdc_pkg::*;

  // ---------------------------------------------------------------- config
  logic [TICK_BITS-1:0] short_ticks_r;
  logic [TICK_BITS-1:0] long_ticks_r;
  logic                 six_key_r;
  logic                 cfg_wr;
  reg_idx_t             cfg_idx;
  thresh_t              thresh;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg_idx    = reg_idx_t'(cfg_paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      short_ticks_r <= SHORT_TICKS_RST;
      long_ticks_r  <= LONG_TICKS_RST;
      six_key_r     <= SIX_KEY_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_SHORT_TICKS: short_ticks_r <= cfg_pwdata[TICK_BITS-1:0];
        REG_LONG_TICKS:  long_ticks_r  <= cfg_pwdata[TICK_BITS-1:0];
        REG_SIX_KEY:     six_key_r     <= cfg_pwdata[0];
        default: ;  // unmapped address: drop the write
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_SHORT_TICKS: cfg_prdata = 32'(short_ticks_r);
      REG_LONG_TICKS:  cfg_prdata = 32'(long_ticks_r);
      REG_SIX_KEY:     cfg_prdata = 32'(six_key_r);
      default:         cfg_prdata = '0;
    endcase
  end

  assign thresh.short_ticks = short_ticks_r;
  assign thresh.long_ticks  = long_ticks_r;

  // ---------------------------------------------------------------- lanes
  logic             accept;
  logic [1:0]       foot_pressed;
  logic [LANES-1:0] held;
  evt_t             lane_evt [LANES];

  assign in_tready    = !out_tvalid || out_tready;
  assign accept       = in_tvalid && in_tready;
  assign foot_pressed = ~in_tdata[7:6];

  // Decode the foot pair into three exclusive channels
  always_comb begin
    held[5:0]   = ~in_tdata[5:0];
    held[6]     = (foot_pressed == 2'b01);
    held[7]     = (foot_pressed == 2'b10);
    held[8]     = (foot_pressed == 2'b11);
    held[14:9]  = ~in_tdata[13:8];
  end

  for (genvar g = 0; g < LANES; g++) begin : g_lane
    kpdc_lane #(
      .COUNT_BITS(COUNT_BITS)
    ) u_lane (
      .clk    (clk),
      .rst_n  (rst_n),
      .advance(accept),
      .held   (held[g]),
      .thresh (thresh),
      .evt    (lane_evt[g])
    );
  end

  // ---------------------------------------------------------------- merge
  logic [17:0] key_events;
  logic [11:0] knob_key_events;

  kpdc_merge u_merge (
    .lane_evt       (lane_evt),
    .six_key_mode   (six_key_r),
    .key_events     (key_events),
    .knob_key_events(knob_key_events)
  );

  // ---------------------------------------------------------------- output register
  logic        out_valid_r;
  logic [31:0] out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  // load the new result on accept, otherwise hold
  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= {2'b00, knob_key_events, key_events};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // ---------------------------------------------------------------- checks
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output register not empty after reset");

  a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_tvalid)
    else $error("accepted item produced no result");

  a_no_bad_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ((out_tdata[29:0] & (out_tdata[29:0] >> 1) & 30'h15555555) == 30'd0))
    else $error("lane reported both short and long in one tick");

  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[31:30] == 2'b00))
    else $error("output pad bits not zero");

endmodule
`default_nettype wire

>>> rtl/kpdc_lane.sv
`default_nettype none
module kpdc_lane #(
  parameter int COUNT_BITS = kpdc_pkg::COUNT_BITS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              advance,
  input  wire logic              held,
  input  wire kpdc_pkg::thresh_t thresh,
  output kpdc_pkg::evt_t         evt
);
  import kpdc_pkg::*;

  localparam int EW = (COUNT_BITS > TICK_BITS + 1) ? COUNT_BITS : TICK_BITS + 1;

  logic [COUNT_BITS-1:0] cnt_r;
  logic [COUNT_BITS-1:0] cnt_nxt;
  logic [EW-1:0]         old_w;
  logic [EW-1:0]         sat_w;
  logic [EW-1:0]         cmax_w;
  logic [EW-1:0]         ceil_w;
  logic [EW-1:0]         next_w;
  logic [EW-1:0]         long_w;
  logic [EW-1:0]         short_w;

  always_comb begin
    old_w   = EW'(cnt_r);
    long_w  = EW'(thresh.long_ticks);
    short_w = EW'(thresh.short_ticks);
    sat_w   = long_w + EW'(1);
    cmax_w  = EW'({COUNT_BITS{1'b1}});
    ceil_w  = (sat_w < cmax_w) ? sat_w : cmax_w;
    next_w  = (old_w < ceil_w) ? old_w + EW'(1) : old_w;
    if (held) begin
      cnt_nxt = next_w[COUNT_BITS-1:0];
      evt     = (next_w != old_w && next_w == long_w) ? EVT_LONG : EVT_NONE;
    end else begin
      cnt_nxt = '0;
      evt     = (old_w > short_w && old_w < long_w) ? EVT_SHORT : EVT_NONE;
    end
  end

  // advance the hold count only on an accepted tick
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (advance) begin
      cnt_r <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

>>> rtl/kpdc_merge.sv
`default_nettype none
module kpdc_merge (
  input  wire kpdc_pkg::evt_t  lane_evt [kpdc_pkg::LANES],
  input  wire logic            six_key_mode,
  output logic [17:0]          key_events,
  output logic [11:0]          knob_key_events
);
  import kpdc_pkg::*;

  logic [17:0] word;

  always_comb begin
    for (int i = 0; i < KEY_LANES; i++) begin
      word[2*i +: 2] = lane_evt[i];
    end
    for (int i = 0; i < KNOB_LANES; i++) begin
      knob_key_events[2*i +: 2] = lane_evt[KEY_LANES + i];
    end
    // four-key panel: drop key one, shift the front keys down
    if (six_key_mode) begin
      key_events = word;
    end else begin
      key_events = (word & FOOT_GROUP_MASK) | ((word & FRONT_GROUP_MASK) >> 2);
    end
  end

endmodule
`default_nettype wire

>>> verif/tb_key_press_duration_classifier_top.sv
`timescale 1ns / 100ps

module tb_key_press_duration_classifier_top;
  import kpdc_pkg::*;

  // Counter width used by the block and by the local lane model
  localparam int CNT_W = COUNT_BITS_DEF;

  // Raw level words (key[5:0], foot[7:6], knob[13:8]); a line at 0 is held
  localparam logic [13:0] LEVELS_IDLE     = 14'h3FFF;
  localparam logic [13:0] LEVELS_ALL_HELD = 14'h0000;
  localparam logic [13:0] LEVELS_FOOT_ONE = 14'h3FBF;
  localparam logic [13:0] LEVELS_FOOT_TWO = 14'h3F7F;
  localparam logic [13:0] LEVELS_FOOT_BOTH = 14'h3F3F;
  localparam logic [13:0] LEVELS_KEY_ONE  = 14'h3FFE;

  // Byte address just past the register list; writes there must be ignored
  localparam logic [3:0] ADDR_UNMAPPED = 4'hC;

  localparam logic [31:0] REG_MASK [3] = '{32'h000F_FFFF, 32'h000F_FFFF, 32'h0000_0001};

  typedef struct {
    logic [17:0] key_ev;
    logic [11:0] knob_ev;
  } tick_events_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;   // key_levels[5:0], foot_levels[7:6], knob_key_levels[13:8]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;       // key_events[17:0], knob_key_events[29:18]
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [3:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  // Shadow of the register file and of the fifteen hold counters
  logic [31:0]     reg_shadow [3] = '{32'(SHORT_TICKS_RST), 32'(LONG_TICKS_RST),
                                      32'(SIX_KEY_RST)};
  string           reg_name [3] = '{"short_ticks", "long_ticks", "six_key_mode"};
  longint unsigned key_hold [KEY_LANES] = '{default: 0};
  longint unsigned knob_hold [KNOB_LANES] = '{default: 0};

  tick_events_t pending_events [$];
  int unsigned  mismatch_count = 0;
  int unsigned  gap_max = 10;
  int unsigned  stall_max = 10;

  key_press_duration_classifier_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always #2 clk = ~clk;

  // Advance one hold counter by one tick and return its event code.
  // Held: count up to the ceiling, report long only on the step onto long_ticks.
  // Released: clear, report short if the count lay strictly between thresholds.
  function automatic evt_t lane_step(input longint unsigned held_ticks, input bit held,
                                     output longint unsigned next_ticks);
    longint unsigned short_t, long_t, top, ceil_v;
    short_t = reg_shadow[REG_SHORT_TICKS];
    long_t  = reg_shadow[REG_LONG_TICKS];
    top     = (64'd1 << CNT_W) - 1;
    ceil_v  = (long_t + 1 < top) ? long_t + 1 : top;
    if (held) begin
      next_ticks = (held_ticks < ceil_v) ? held_ticks + 1 : held_ticks;
      return (next_ticks != held_ticks && next_ticks == long_t) ? EVT_LONG : EVT_NONE;
    end
    next_ticks = 0;
    return (held_ticks > short_t && held_ticks < long_t) ? EVT_SHORT : EVT_NONE;
  endfunction

  // Work out the event words of one tick and advance the shadow counters
  function automatic void predict_events(input logic [13:0] levels,
                                         output logic [17:0] key_ev,
                                         output logic [11:0] knob_ev);
    logic [5:0]      keys_held, knobs_held;
    logic [1:0]      foot_held;
    longint unsigned next_ticks;
    evt_t            code;
    int              i;
    keys_held  = ~levels[5:0];
    foot_held  = ~levels[7:6];
    knobs_held = ~levels[13:8];
    key_ev  = '0;
    knob_ev = '0;
    for (i = 0; i < 6; i++) begin
      code = lane_step(key_hold[i], keys_held[i], next_ticks);
      key_hold[i] = next_ticks;
      key_ev[2*i +: 2] = code;
    end
    // Foot lines decode into exclusive channels: one only, two only, both
    for (i = 0; i < 3; i++) begin
      code = lane_step(key_hold[6+i], foot_held == 2'(i + 1), next_ticks);
      key_hold[6+i] = next_ticks;
      key_ev[12 + 2*i +: 2] = code;
    end
    for (i = 0; i < KNOB_LANES; i++) begin
      code = lane_step(knob_hold[i], knobs_held[i], next_ticks);
      knob_hold[i] = next_ticks;
      knob_ev[2*i +: 2] = code;
    end
    // Four-key mode: drop key one and shift the front group down
    if (reg_shadow[REG_SIX_KEY][0] == 1'b0)
      key_ev = (key_ev & FOOT_GROUP_MASK) | ((key_ev & FRONT_GROUP_MASK) >> 2);
  endfunction

  // Present one item after a random gap, wait for acceptance, queue its events
  task automatic send_item(input logic [13:0] levels);
    int unsigned  gap;
    tick_events_t ev;
    gap = $urandom_range(gap_max, 0);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {2'b00, levels};
    do @(posedge clk); while (!in_tready);
    predict_events(levels, ev.key_ev, ev.knob_ev);
    pending_events.push_back(ev);
  endtask

  task automatic send_repeat(input logic [13:0] levels, input int unsigned n);
    repeat (n) send_item(levels);
  endtask

  // Stop sending and hold until every queued result has been taken
  task automatic settle();
    in_tvalid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [3:0] addr, input logic [31:0] val);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    if (addr[3:2] <= REG_SIX_KEY)
      reg_shadow[addr[3:2]] = val & REG_MASK[addr[3:2]];
    @(posedge clk);
  endtask

  task automatic cfg_read(input logic [3:0] addr, output logic [31:0] val);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= addr;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    val = cfg_prdata;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  // Read back every register and compare with the shadow copy
  task automatic check_regs();
    logic [31:0] rd;
    int          i;
    for (i = 0; i < 3; i++) begin
      cfg_read({i[1:0], 2'b00}, rd);
      if ((rd & REG_MASK[i]) !== reg_shadow[i]) begin
        $error("%s: expected %0d, actual %0d", reg_name[i], reg_shadow[i], rd & REG_MASK[i]);
        mismatch_count++;
      end
    end
  endtask

  // Drain the block, then write all three registers and read them back
  task automatic program_thresholds(input logic [19:0] short_t, input logic [19:0] long_t,
                                    input bit six_keys);
    settle();
    cfg_write({REG_SHORT_TICKS, 2'b00}, 32'(short_t));
    cfg_write({REG_LONG_TICKS, 2'b00}, 32'(long_t));
    cfg_write({REG_SIX_KEY, 2'b00}, 32'(six_keys));
    check_regs();
  endtask

  // Reset values, and a write past the register list that must change nothing
  task automatic test_register_access();
    check_regs();
    cfg_write(ADDR_UNMAPPED, 32'hFFFF_FFFF);
    check_regs();
  endtask

  task automatic test_directed_edges();
    // Reset thresholds: short presses need over a thousand ticks, so nothing fires
    send_item(LEVELS_IDLE);
    send_item(LEVELS_ALL_HELD);
    send_item(LEVELS_IDLE);

    // Smallest thresholds: one tick is short, two ticks is long
    program_thresholds(20'd0, 20'd2, 1'b1);
    send_item(LEVELS_ALL_HELD);
    send_item(LEVELS_IDLE);
    send_repeat(LEVELS_ALL_HELD, 2);
    send_item(LEVELS_IDLE);
    // Hold past the ceiling: long fires once, release after saturation is silent
    send_repeat(LEVELS_ALL_HELD, 4);
    send_item(LEVELS_IDLE);
    // Step between foot channels without a released tick in between
    send_item(LEVELS_FOOT_ONE);
    send_item(LEVELS_FOOT_TWO);
    send_item(LEVELS_FOOT_BOTH);
    send_item(LEVELS_IDLE);

    // Four-key remap: key one's short and long presses are lost
    program_thresholds(20'd0, 20'd2, 1'b0);
    send_item(LEVELS_ALL_HELD);
    send_item(LEVELS_IDLE);
    send_repeat(LEVELS_KEY_ONE, 2);

    // Largest thresholds
    program_thresholds(20'hFFFFF, 20'hFFFFF, 1'b1);
    send_item(LEVELS_ALL_HELD);
    send_item(LEVELS_IDLE);
  endtask

  // Mostly held runs of random length with random content, some single noise
  // items and stray bit flips inside runs; drain once halfway through
  task automatic run_press_phase(input int unsigned n_items);
    logic [13:0] levels;
    int unsigned run_left, span, sent;
    run_left = 0;
    levels   = LEVELS_IDLE;
    span     = reg_shadow[REG_LONG_TICKS] + 3;
    for (sent = 0; sent < n_items; sent++) begin
      if (run_left == 0) begin
        levels   = 14'($urandom);
        run_left = ($urandom_range(99, 0) < 85) ? $urandom_range(span, 1) : 1;
      end else if ($urandom_range(9, 0) == 0) begin
        levels[$urandom_range(13, 0)] ^= 1'b1;
      end
      run_left--;
      send_item(levels);
      if (sent == n_items / 2)
        settle();
    end
  endtask

  task automatic test_random_runs();
    int unsigned ph, long_t;
    for (ph = 0; ph < 8; ph++) begin
      case (ph)
        0: program_thresholds(20'd0, 20'd2, 1'b1);
        1: begin
          // Short threshold at long-1: no short press can qualify
          long_t = $urandom_range(12, 3);
          program_thresholds(20'(long_t - 1), 20'(long_t), 1'b0);
        end
        7: begin
          long_t = $urandom_range(160, 60);
          program_thresholds(20'($urandom_range(long_t, 0)), 20'(long_t), 1'($urandom));
        end
        default: begin
          long_t = $urandom_range(24, 2);
          program_thresholds(20'($urandom_range(long_t + 2, 0)), 20'(long_t), 1'($urandom));
        end
      endcase
      // Run one phase back to back on both sides
      gap_max   = (ph == 3) ? 0 : 10;
      stall_max = (ph == 3) ? 0 : 10;
      run_press_phase(200);
    end
    gap_max   = 10;
    stall_max = 10;
  endtask

  // Result side: stall a random number of cycles, then take one item
  initial begin : result_sink
    int unsigned stall;
    forever begin
      stall = $urandom_range(stall_max, 0);
      if (stall != 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!(out_tvalid && rst_n));
    end
  end

  // Compare each taken item with the oldest prediction
  always @(posedge clk) begin : check_results
    tick_events_t exp_ev;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_events.size() == 0) begin
        $error("unexpected result item: out_tdata %h", out_tdata);
        mismatch_count++;
      end else begin
        exp_ev = pending_events.pop_front();
        if (out_tdata[17:0] !== exp_ev.key_ev) begin
          $error("key_events: expected %h, actual %h", exp_ev.key_ev, out_tdata[17:0]);
          mismatch_count++;
        end
        if (out_tdata[29:18] !== exp_ev.knob_ev) begin
          $error("knob_key_events: expected %h, actual %h", exp_ev.knob_ev, out_tdata[29:18]);
          mismatch_count++;
        end
      end
    end
  end

  // Bound the run well past the slowest legal completion
  initial begin : watchdog
    #2_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  initial begin : main_sequence
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_register_access();
    test_directed_edges();
    test_random_runs();
    // Drain what is still in flight, then let the pipeline go quiet before the verdict
    settle();
    repeat (5) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/kpdc_pkg.sv
rtl/kpdc_lane.sv
rtl/kpdc_merge.sv
rtl/key_press_duration_classifier_top.sv
verif/tb_key_press_duration_classifier_top.sv
